// ===== rtl/bellman_ford_shortest_path_core_defines.svh =====
// Assertion macros for the shortest path core.
`ifndef BELLMAN_FORD_SHORTEST_PATH_CORE_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BFSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfsp_pkg.sv =====
// Shared types and constants of the shortest path core.
`default_nettype none

package bfsp_pkg;

  localparam int VID_W   = 6;   // vertex id field
  localparam int VCNT_W  = 7;   // vertex count register and vertex counters
  localparam int KIND_W  = 2;
  localparam int WIN_W   = 16;  // edge weight field on the input channel
  localparam int DIST_W  = 22;  // stored and reported distance

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam int DIST_MAX = 2097151;
  localparam int DIST_MIN = -2097152;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_RUN   = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_EREAD,
    S_DREAD,
    S_RELAX,
    S_NEG,
    S_EMIT_RD,
    S_EMIT_LD
  } bfsp_state_t;

endpackage

`default_nettype wire

// ===== rtl/bfsp_if.sv =====
// Channel interfaces of the shortest path core: command, result and configuration.
`default_nettype none

interface bfsp_in_if
  import bfsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [VID_W-1:0]         edge_from;
  logic [VID_W-1:0]         edge_to;
  logic signed [WIN_W-1:0]  edge_weight;
  logic [VID_W-1:0]         start_vertex;

  modport source (output valid, kind, edge_from, edge_to, edge_weight, start_vertex,
                  input ready);
  modport sink   (input valid, kind, edge_from, edge_to, edge_weight, start_vertex,
                  output ready);
endinterface

interface bfsp_out_if
  import bfsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [VID_W-1:0]         vertex_id;
  logic signed [DIST_W-1:0] distance;
  logic [VID_W-1:0]         predecessor;
  logic                     reachable;
  logic                     negative_cycle;
  logic                     edge_overflow;
  logic                     last_result;

  modport source (output valid, vertex_id, distance, predecessor, reachable,
                  negative_cycle, edge_overflow, last_result, input ready);
  modport sink   (input valid, vertex_id, distance, predecessor, reachable,
                  negative_cycle, edge_overflow, last_result, output ready);
endinterface

interface bfsp_cfg_if
  import bfsp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VCNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bellman_ford_shortest_path_core.sv =====
// Bellman-Ford single-source shortest path core with edge store and sequencer.
// Add-edge and clear transactions are handled in the idle state, so edges stream
// in at one per cycle while no run is in progress. A run transaction occupies
// the core until its results are queued. Each pass steps through every active
// vertex and then closes the pass. For every reached source vertex it reads each
// stored edge and tries to relax those that leave that vertex and land inside
// the vertex count. A run makes n passes for n active vertices. The last pass is
// the negative cycle check, which stops at the first edge that could still relax.
// Each result then goes through a read state and a load state, and waits in the
// load state while the output is still full. The pace of the sweep is set by the
// single distance store, read and written by one shared add/compare/saturate
// unit, one edge at a time. Results leave through an output register, so the
// next command is taken while the last result still waits. Distances saturate
// to the 22-bit signed range; unreachable vertices report distance 0 and
// themselves as predecessor. Edges beyond capacity are dropped and flagged on
// every later result until a clear.
`default_nettype none

`include "bellman_ford_shortest_path_core_defines.svh"

module bellman_ford_shortest_path_core
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  bfsp_in_if.sink      in_ch,
  bfsp_out_if.source   out_ch,
  bfsp_cfg_if.sink     cfg_ch
);

  localparam int VX_W  = $clog2(MAX_VERTICES);
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W  = $clog2(MAX_EDGES + 1);
  localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
  localparam int E_W   = 2 * VID_W + WEIGHT_BITS;

  localparam logic signed [SUM_W-1:0] SUM_DMAX = SUM_W'(DIST_MAX);
  localparam logic signed [SUM_W-1:0] SUM_DMIN = SUM_W'(DIST_MIN);
  localparam logic [ET_W-1:0]   EDGE_CAP = ET_W'(MAX_EDGES);
  localparam logic [VCNT_W-1:0] VMAX     = VCNT_W'(MAX_VERTICES);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  bfsp_state_t              state_r, state_nxt;
  logic [VCNT_W-1:0]        vc_r;                      // vertex_count register
  logic [ET_W-1:0]          edge_total_r, edge_total_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [VCNT_W-1:0]        n_r, n_nxt;                // active vertices of this run
  logic [VCNT_W-1:0]        j_r, j_nxt;                // source vertex being swept
  logic [VCNT_W-1:0]        p_r, p_nxt;                // pass number
  logic [VCNT_W-1:0]        v_r, v_nxt;                // result vertex
  logic [ET_W-1:0]          e_r, e_nxt;                // edge index
  logic [MAX_VERTICES-1:0]  reached_r, reached_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [VID_W-1:0]         out_vid_r, out_vid_nxt;
  logic signed [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic [VID_W-1:0]         out_pred_r, out_pred_nxt;
  logic                     out_reach_r, out_reach_nxt;
  logic                     out_neg_r, out_neg_nxt;
  logic                     out_ovf_r, out_ovf_nxt;    // overflow flag as of the run
  logic                     out_last_r, out_last_nxt;

  // Memories and their registered read data
  logic [E_W-1:0]           edge_mem [MAX_EDGES];
  logic [E_W-1:0]           edge_rd_r;
  logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES];
  logic [VID_W-1:0]         pred_mem [MAX_VERTICES];
  logic signed [DIST_W-1:0] dist_a_r, dist_b_r;
  logic [VID_W-1:0]         pred_b_r;

  // ---------------------------------------------------------------------------
  // Channel decode
  // ---------------------------------------------------------------------------
  logic                   in_acc, add_acc, run_acc, edge_full, out_free;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [VCNT_W-1:0]      n_clamp;
  logic [VCNT_W-1:0]      start_ext;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign add_acc   = in_acc && (in_ch.kind == KIND_ADD);
  assign run_acc   = in_acc && (in_ch.kind == KIND_RUN);
  assign edge_full = (edge_total_r == EDGE_CAP);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign start_ext = {1'b0, in_ch.start_vertex};

  // 0 behaves as 1, anything above capacity as capacity
  assign n_clamp = (vc_r == '0) ? VCNT_W'(1) : ((vc_r > VMAX) ? VMAX : vc_r);

  // Weight keeps its low WEIGHT_BITS bits; a wider weight sees the field unsigned.
  generate
    if (WEIGHT_BITS <= WIN_W) begin : g_w_narrow
      assign w_in = in_ch.edge_weight[WEIGHT_BITS-1:0];
    end else begin : g_w_wide
      assign w_in = {{(WEIGHT_BITS - WIN_W){1'b0}}, in_ch.edge_weight};
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Edge word fields and the shared relax unit
  // ---------------------------------------------------------------------------
  logic [VID_W-1:0]              e_src, e_dst;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic signed [SUM_W-1:0]       sum, dist_b_ext;
  logic signed [DIST_W-1:0]      sum_sat;
  logic                          edge_hit, relax, check_pass, last_edge;
  logic [VX_W-1:0]               j_idx, t_idx, v_idx;

  assign e_src = edge_rd_r[E_W-1 -: VID_W];
  assign e_dst = edge_rd_r[WEIGHT_BITS +: VID_W];
  assign e_w   = edge_rd_r[WEIGHT_BITS-1:0];

  assign j_idx = j_r[VX_W-1:0];
  assign t_idx = e_dst[VX_W-1:0];
  assign v_idx = v_r[VX_W-1:0];

  assign edge_hit   = ({1'b0, e_src} == j_r) && ({1'b0, e_dst} < n_r);
  assign check_pass = (p_r == n_r - VCNT_W'(1));
  assign last_edge  = (ET_W'(e_r + 1'b1) == edge_total_r);

  assign sum        = SUM_W'(dist_a_r) + SUM_W'(e_w);
  assign dist_b_ext = SUM_W'(dist_b_r);
  assign relax      = !reached_r[t_idx] || (sum < dist_b_ext);
  assign sum_sat    = (sum > SUM_DMAX) ? DIST_W'(SUM_DMAX) :
                      (sum < SUM_DMIN) ? DIST_W'(SUM_DMIN) : sum[DIST_W-1:0];

  // Distance/predecessor store port control
  logic                     dist_we;
  logic [VX_W-1:0]          waddr;
  logic signed [DIST_W-1:0] wdist;
  logic [VID_W-1:0]         wpred;
  logic [VX_W-1:0]          rd_b_addr;
  logic                     edge_we;

  assign rd_b_addr = ((state_r == S_EMIT_RD) || (state_r == S_EMIT_LD)) ? v_idx : t_idx;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    edge_total_nxt = edge_total_r;
    ovf_nxt        = ovf_r;
    n_nxt          = n_r;
    j_nxt          = j_r;
    p_nxt          = p_r;
    v_nxt          = v_r;
    e_nxt          = e_r;
    reached_nxt    = reached_r;
    edge_we        = 1'b0;
    dist_we        = 1'b0;
    waddr          = t_idx;
    wdist          = sum_sat;
    wpred          = j_r[VID_W-1:0];
    out_vid_nxt    = out_vid_r;
    out_dist_nxt   = out_dist_r;
    out_pred_nxt   = out_pred_r;
    out_reach_nxt  = out_reach_r;
    out_neg_nxt    = out_neg_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.kind)
            KIND_ADD: begin
              if (!edge_full) begin
                edge_we        = 1'b1;
                edge_total_nxt = ET_W'(edge_total_r + 1'b1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_CLEAR: begin
              edge_total_nxt = '0;
              ovf_nxt        = 1'b0;
            end
            KIND_RUN: begin
              n_nxt       = n_clamp;
              j_nxt       = '0;
              p_nxt       = '0;
              reached_nxt = '0;
              // source sits at distance 0 and is its own predecessor
              if (start_ext < n_clamp) begin
                reached_nxt[in_ch.start_vertex[VX_W-1:0]] = 1'b1;
                dist_we = 1'b1;
                waddr   = in_ch.start_vertex[VX_W-1:0];
                wdist   = '0;
                wpred   = in_ch.start_vertex;
              end
              state_nxt = S_PASS;
            end
            default: ;  // unused kind: dropped
          endcase
        end
      end

      S_PASS: begin
        if (j_r == n_r) begin
          if (check_pass) begin
            v_nxt     = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            p_nxt = p_r + VCNT_W'(1);
            j_nxt = '0;
          end
        end else if (!reached_r[j_idx] || (edge_total_r == '0)) begin
          j_nxt = j_r + VCNT_W'(1);
        end else begin
          e_nxt     = '0;
          state_nxt = S_EREAD;
        end
      end

      S_EREAD: state_nxt = S_DREAD;

      S_DREAD: begin
        if (edge_hit) begin
          state_nxt = S_RELAX;
        end else if (last_edge) begin
          j_nxt     = j_r + VCNT_W'(1);
          state_nxt = S_PASS;
        end else begin
          e_nxt     = ET_W'(e_r + 1'b1);
          state_nxt = S_EREAD;
        end
      end

      S_RELAX: begin
        if (relax && check_pass) begin
          state_nxt = S_NEG;
        end else begin
          if (relax) begin
            dist_we            = 1'b1;
            reached_nxt[t_idx] = 1'b1;
          end
          if (last_edge) begin
            j_nxt     = j_r + VCNT_W'(1);
            state_nxt = S_PASS;
          end else begin
            e_nxt     = ET_W'(e_r + 1'b1);
            state_nxt = S_EREAD;
          end
        end
      end

      S_NEG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vid_nxt   = '0;
          out_dist_nxt  = '0;
          out_pred_nxt  = '0;
          out_reach_nxt = 1'b0;
          out_neg_nxt   = 1'b1;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_EMIT_RD: state_nxt = S_EMIT_LD;

      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vid_nxt   = v_r[VID_W-1:0];
          out_reach_nxt = reached_r[v_idx];
          out_dist_nxt  = reached_r[v_idx] ? dist_b_r : '0;
          out_pred_nxt  = reached_r[v_idx] ? pred_b_r : v_r[VID_W-1:0];
          out_neg_nxt   = 1'b0;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = (v_r == n_r - VCNT_W'(1));
          if (v_r == n_r - VCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            v_nxt     = v_r + VCNT_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vc_r         <= VCOUNT_RESET;
      edge_total_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_total_r <= edge_total_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        vc_r <= cfg_ch.data;
      end
    end
  end

  // Counters and payload; only meaningful inside a run
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    p_r         <= p_nxt;
    v_r         <= v_nxt;
    e_r         <= e_nxt;
    reached_r   <= reached_nxt;
    out_vid_r   <= out_vid_nxt;
    out_dist_r  <= out_dist_nxt;
    out_pred_r  <= out_pred_nxt;
    out_reach_r <= out_reach_nxt;
    out_neg_r   <= out_neg_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Edge store: written at the fill count, read at the sweep index
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total_r[EA_W-1:0]] <= {in_ch.edge_from, in_ch.edge_to, w_in};
    end
    edge_rd_r <= edge_mem[e_r[EA_W-1:0]];
  end

  // Distance and predecessor stores: one write, reads at source and target/result
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[waddr] <= wdist;
      pred_mem[waddr] <= wpred;
    end
    dist_a_r <= dist_mem[j_idx];
    dist_b_r <= dist_mem[rd_b_addr];
    pred_b_r <= pred_mem[rd_b_addr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.vertex_id      = out_vid_r;
  assign out_ch.distance       = out_dist_r;
  assign out_ch.predecessor    = out_pred_r;
  assign out_ch.reachable      = out_reach_r;
  assign out_ch.negative_cycle = out_neg_r;
  assign out_ch.edge_overflow  = out_ovf_r;
  assign out_ch.last_result    = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BFSP_ASSERT_NEXT(a_run_starts, clk, rst_n, run_acc, state_r != S_IDLE, "run transaction did not start a sweep")
  `BFSP_ASSERT_NEXT(a_overflow_flag, clk, rst_n, add_acc && edge_full, ovf_r && (edge_total_r == EDGE_CAP), "dropped edge not flagged")
  `BFSP_ASSERT_IMPL(a_check_no_write, clk, rst_n, dist_we, (state_r == S_IDLE) || !check_pass, "distance written during check pass")

endmodule

`default_nettype wire

// ===== tb/sv/bfsp_path_checker.sv =====
// Shortest path checker: watches the channels, predicts every run and compares results.
module bfsp_path_checker
  import bfsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bfsp_in_if   cmd_mon,
  bfsp_out_if  res_mon,
  bfsp_cfg_if  cfg_mon,
  output int   fail_count,
  output int   expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VID_W-1:0]  vertex_id;
    logic [DIST_W-1:0] distance;
    logic [VID_W-1:0]  predecessor;
    logic              reachable;
    logic              negative_cycle;
    logic              edge_overflow;
    logic              last_result;
  } path_result_t;

  // Edge list as loaded; weight field width equals WEIGHT_BITS, so plain sign extension.
  logic [VID_W-1:0]  edge_src [MAX_EDGES_DEF];
  logic [VID_W-1:0]  edge_dst [MAX_EDGES_DEF];
  int                edge_wt  [MAX_EDGES_DEF];
  int                edge_cnt;
  bit                edges_dropped;
  logic [VCNT_W-1:0] vcount;

  int                dist_now [MAX_VERTICES_DEF];
  bit                reached  [MAX_VERTICES_DEF];
  logic [VID_W-1:0]  pred_now [MAX_VERTICES_DEF];

  path_result_t      expected_paths [$];

  function automatic void queue_expected(path_result_t r);
    expected_paths = {expected_paths, r};
  endfunction

  function automatic int clamp_dist(longint s);
    if (s > DIST_MAX) return DIST_MAX;
    if (s < DIST_MIN) return DIST_MIN;
    return int'(s);
  endfunction

  // One pass in source-vertex order; with probe set, only reports whether anything relaxes.
  function automatic bit relax_sweep(int n, bit probe);
    longint sum;
    int     t;
    for (int j = 0; j < n; j++) begin
      if (!reached[j]) continue;
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_src[e] != j) continue;
        t = edge_dst[e];
        if (t >= n) continue;
        sum = longint'(dist_now[j]) + longint'(edge_wt[e]);
        if (!reached[t] || sum < longint'(dist_now[t])) begin
          if (probe) return 1'b1;
          dist_now[t] = clamp_dist(sum);
          reached[t]  = 1'b1;
          pred_now[t] = VID_W'(j);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void solve_shortest_paths(logic [VID_W-1:0] start);
    int           n;
    bit           neg;
    path_result_t r;
    n = (vcount == 0) ? 1 :
        (int'(vcount) > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vcount);
    for (int v = 0; v < MAX_VERTICES_DEF; v++) begin
      dist_now[v] = 0;
      reached[v]  = 1'b0;
      pred_now[v] = VID_W'(v);
    end
    if (int'(start) < n) reached[start] = 1'b1;
    for (int p = 0; p + 1 < n; p++) void'(relax_sweep(n, 1'b0));
    neg = relax_sweep(n, 1'b1);
    if (neg) begin
      r.vertex_id      = '0;
      r.distance       = '0;
      r.predecessor    = '0;
      r.reachable      = 1'b0;
      r.negative_cycle = 1'b1;
      r.edge_overflow  = edges_dropped;
      r.last_result    = 1'b1;
      queue_expected(r);
    end else begin
      for (int v = 0; v < n; v++) begin
        r.vertex_id      = VID_W'(v);
        r.distance       = reached[v] ? DIST_W'(dist_now[v]) : '0;
        r.predecessor    = reached[v] ? pred_now[v] : VID_W'(v);
        r.reachable      = reached[v];
        r.negative_cycle = 1'b0;
        r.edge_overflow  = edges_dropped;
        r.last_result    = (v + 1 == n);
        queue_expected(r);
      end
    end
  endfunction

  function automatic string describe(path_result_t r);
    return $sformatf("vertex=%0d dist=%0d pred=%0d reach=%0b neg=%0b ovf=%0b last=%0b",
                     r.vertex_id, $signed(r.distance), r.predecessor, r.reachable,
                     r.negative_cycle, r.edge_overflow, r.last_result);
  endfunction

  function automatic void check_result();
    path_result_t got;
    path_result_t want;
    got.vertex_id      = res_mon.vertex_id;
    got.distance       = res_mon.distance;
    got.predecessor    = res_mon.predecessor;
    got.reachable      = res_mon.reachable;
    got.negative_cycle = res_mon.negative_cycle;
    got.edge_overflow  = res_mon.edge_overflow;
    got.last_result    = res_mon.last_result;
    if (expected_paths.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, got %s", $time, describe(got));
      return;
    end
    want = expected_paths.pop_front();
    if (got.vertex_id !== want.vertex_id || got.distance !== want.distance ||
        got.predecessor !== want.predecessor || got.reachable !== want.reachable ||
        got.negative_cycle !== want.negative_cycle ||
        got.edge_overflow !== want.edge_overflow || got.last_result !== want.last_result)
    begin
      fail_count++;
      $display("%0t: result mismatch, expected %s, got %s", $time, describe(want),
               describe(got));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt      = 0;
      edges_dropped = 1'b0;
      vcount        = VCOUNT_RESET;
      fail_count    = 0;
      expected_paths.delete();
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) vcount = cfg_mon.data;
      if (cmd_mon.valid === 1'b1 && cmd_mon.ready === 1'b1) begin
        case (cmd_mon.kind)
          KIND_ADD: begin
            if (edge_cnt < MAX_EDGES_DEF) begin
              edge_src[edge_cnt] = cmd_mon.edge_from;
              edge_dst[edge_cnt] = cmd_mon.edge_to;
              edge_wt[edge_cnt]  = int'(cmd_mon.edge_weight);
              edge_cnt++;
            end else begin
              edges_dropped = 1'b1;
            end
          end
          KIND_RUN: solve_shortest_paths(cmd_mon.start_vertex);
          KIND_CLEAR: begin
            edge_cnt      = 0;
            edges_dropped = 1'b0;
          end
          default: ;
        endcase
      end
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) check_result();
    end
    expected_left = expected_paths.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the shortest path testbench: clock, reset, stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfsp_pkg::*;

  // Budget: about 250 commands, a few dozen small runs and a handful of 64-vertex runs
  // with tiny graphs stay far below the limit even with the slowest flow-control
  // phases.
  localparam int    CYCLE_LIMIT   = 6_000_000;
  localparam int    HOLD_CYCLES   = 500;  // long result back-pressure stretch
  localparam int    SETTLE_CYCLES = 32;   // core idle margin after the last result
  localparam int    RANDOM_ITEMS  = 225;
  localparam kind_t KIND_UNUSED   = 2'd3; // reserved opcode, core drops it

  logic clk;
  logic rst_n;

  bfsp_in_if  in_ch ();
  bfsp_out_if out_ch ();
  bfsp_cfg_if cfg_ch ();

  int fail_count;
  int expected_left;
  int idle_pct      = 0;  // chance per cycle the command side sits out
  int stall_pct     = 0;  // chance per cycle the result side deasserts ready
  int hold_requests = 0;  // bumped by stimulus, served by the result-side process
  int holds_served  = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int items_sent    = 0;  // commands the core acts on (reserved opcode not counted)
  int edges_loaded  = 0;  // local mirror, only to keep run cost bounded
  int cur_n         = MAX_VERTICES_DEF;

  bellman_ford_shortest_path_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bfsp_path_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_mon       (in_ch),
    .res_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the core hangs or loses results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls per phase, plus a long hold-off on request that is
  // counted here so the command side keeps pushing while results back up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_requests > holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One command transaction. Valid stays high from one transaction into the next when
  // there is no gap, so it is never dropped and re-raised in the same step.
  task automatic send_item(kind_t k, logic [VID_W-1:0] from_v, logic [VID_W-1:0] to_v,
                           logic [WIN_W-1:0] wt, logic [VID_W-1:0] start);
    int gaps;
    gaps = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gaps < 40) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      gaps++;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= k;
    in_ch.edge_from    <= from_v;
    in_ch.edge_to      <= to_v;
    in_ch.edge_weight  <= wt;
    in_ch.start_vertex <= start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  // Unused fields of each command carry random values.
  task automatic add_edge(int from_v, int to_v, int wt);
    send_item(KIND_ADD, VID_W'(from_v), VID_W'(to_v), WIN_W'(wt), VID_W'($urandom));
    edges_loaded++;
  endtask

  task automatic run_from(int start);
    send_item(KIND_RUN, VID_W'($urandom), VID_W'($urandom), WIN_W'($urandom),
              VID_W'(start));
  endtask

  task automatic clear_edges();
    send_item(KIND_CLEAR, VID_W'($urandom), VID_W'($urandom), WIN_W'($urandom),
              VID_W'($urandom));
    edges_loaded = 0;
  endtask

  // Command side goes quiet until every predicted result is back, then the core gets
  // a margin to finish any trailing work.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the core idle.
  task automatic write_vertex_count(int value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= VCNT_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_n = (value == 0) ? 1 : (value > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : value;
  endtask

  // Mostly in-range vertices so runs actually reach things; some land anywhere.
  function automatic int pick_vertex(int n);
    if ($urandom_range(99) < 85) return $urandom_range(n - 1);
    return $urandom_range(63);
  endfunction

  // Mostly small non-negative weights; some negatives to form cycles; some full range.
  function automatic int pick_weight();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(50);
    if (sel < 85) return int'($urandom_range(70)) - 20;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  initial begin
    int seq;
    int target;
    int nsel;
    int val;
    int k;
    int runs;
    bit big;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ADD;
    in_ch.edge_from    = '0;
    in_ch.edge_to      = '0;
    in_ch.edge_weight  = '0;
    in_ch.start_vertex = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed part, no idling ----
    // Empty graph at the reset vertex count: 64 results, only the start reached.
    run_from(0);
    // Small graph: negative edge, weight extremes, zero weight, an edge to a vertex
    // beyond the count and one from the top vertex, both skipped at eight vertices.
    add_edge(0, 1, 5);
    add_edge(1, 2, -3);
    add_edge(0, 2, 4);
    add_edge(2, 3, 32767);
    add_edge(3, 4, -32768);
    add_edge(4, 5, 0);
    add_edge(2, 40, -7);
    add_edge(63, 0, 1);
    send_item(KIND_UNUSED, VID_W'($urandom), VID_W'($urandom), WIN_W'($urandom),
              VID_W'($urandom));
    write_vertex_count(8);
    run_from(0);
    run_from(63);   // start beyond the count: nothing reached
    run_from(2);
    // Stacked negative self loops drive the distance past the bottom of its range;
    // the check pass then reports a negative cycle. Count 127 acts as 64.
    clear_edges();
    for (int i = 0; i < 8; i++) add_edge(0, 0, -32768);
    write_vertex_count(127);
    run_from(0);
    // Count 0 acts as 1: no relaxation passes, only the check pass.
    write_vertex_count(0);
    run_from(0);
    run_from(5);

    // ---- Random part: short graphs, each with its own count, then a few runs ----
    target = items_sent + RANDOM_ITEMS;
    seq    = 0;
    while (items_sent < target) begin
      // Flow-control phase changes every four graphs.
      case ((seq / 4) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase

      nsel = $urandom_range(99);
      if (seq == 2)       val = 8;
      else if (nsel < 5)  val = $urandom_range(64, 127);
      else if (nsel < 10) val = 0;
      else                val = $urandom_range(1, 10);
      write_vertex_count(val);   // waits for all results first
      big = (cur_n > 16);

      // Large counts get a fresh, tiny graph so runs stay cheap.
      if (big || edges_loaded > 40 || $urandom_range(99) < 80) clear_edges();
      k = big ? $urandom_range(6) : $urandom_range(16);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(99) < 8)
          send_item(KIND_UNUSED, VID_W'($urandom), VID_W'($urandom), WIN_W'($urandom),
                    VID_W'($urandom));
        add_edge(pick_vertex(cur_n), pick_vertex(cur_n), pick_weight());
      end

      // One graph runs against a long result hold-off; commands keep coming.
      if (seq == 2) hold_requests++;
      runs = $urandom_range(1, 3);
      for (int i = 0; i < runs; i++) begin
        run_from(pick_vertex(cur_n));
        if (!big && $urandom_range(99) < 10)
          add_edge(pick_vertex(cur_n), pick_vertex(cur_n), pick_weight());
        if ($urandom_range(99) < 4) clear_edges();
      end
      if (seq == 2)
        for (int i = 0; i < 4; i++)
          add_edge(pick_vertex(cur_n), pick_vertex(cur_n), pick_weight());
      seq++;
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
